// ===== hw/rtl/tccle_pkg.sv =====
// shared types and constants of the text console cursor and line editor
`default_nettype none

package tccle_pkg;

    // console geometry limits and line capacity
    localparam int unsigned MAX_COLUMNS   = 256;
    localparam int unsigned MAX_ROWS      = 128;
    localparam int unsigned LINE_CAPACITY = 256;

    // effective limits after clamping to the field widths
    localparam int unsigned COL_LIMIT = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
    localparam int unsigned ROW_LIMIT = (MAX_ROWS < 128) ? MAX_ROWS : 128;
    localparam int unsigned LINE_CAP  = (LINE_CAPACITY - 1 < 255) ? LINE_CAPACITY - 1 : 255;

    // register reset values
    localparam logic [8:0] COLUMNS_RESET = 9'd80;
    localparam logic [7:0] ROWS_RESET    = 8'd25;

    // configuration port
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    // command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = PTR_W + 1;

    // character codes
    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_NL = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_SP = 8'd32;
    localparam logic [7:0] CH_GT = 8'd62;

    typedef enum logic [1:0] {
        KIND_DISPLAY = 2'd0,
        KIND_KEY     = 2'd1,
        KIND_CLEAR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ACT_DRAW  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_LINE  = 2'd2
    } t_action;

    typedef enum logic [0:0] {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } t_reg;

    // classified command carried from front to back
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_NEWLINE,
        OP_RETURN,
        OP_ERASE,
        OP_DRAW,
        OP_KEY_ENTER,
        OP_KEY_BACK,
        OP_KEY_RETURN,
        OP_KEY_DRAW
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] code;
    } t_cmd;

    // queue entry with its valid flag (push side and head side)
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qword;

    // last usable column and row of the screen
    typedef struct packed {
        logic [7:0] col_last;
        logic [6:0] row_last;
    } t_geom;

    // configuration port request
    typedef struct packed {
        logic              psel;
        logic              penable;
        logic              pwrite;
        logic [ADDR_W-1:0] paddr;
        logic [DATA_W-1:0] pwdata;
    } t_apb_req;

endpackage

`default_nettype wire

// ===== hw/rtl/tccle_if.sv =====
// valid/ready channel interfaces for input items and result items
`default_nettype none

interface tccle_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_code;

    modport source (output valid, kind, char_code, input ready);
    modport sink   (input valid, kind, char_code, output ready);
endinterface

interface tccle_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] cell_column;
    logic [6:0] cell_row;
    logic [7:0] glyph;
    logic [7:0] line_length;
    logic       last;

    modport source (output valid, action, cell_column, cell_row, glyph, line_length, last,
                    input ready);
    modport sink   (input valid, action, cell_column, cell_row, glyph, line_length, last,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tccle_cfg.sv =====
// configuration registers and clamped screen geometry
`default_nettype none

module tccle_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire tccle_pkg::t_apb_req            i_req,
    output logic [tccle_pkg::DATA_W-1:0]        o_prdata,
    output tccle_pkg::t_geom                    o_geom
);

    logic [8:0]      r_columns;
    logic [7:0]      r_rows;
    logic            wr_en;
    tccle_pkg::t_reg sel;

    // clamp raw register values to the usable screen
    function automatic tccle_pkg::t_geom clamp_geom(input logic [8:0] cols,
                                                    input logic [7:0] rows);
        tccle_pkg::t_geom g;
        logic [8:0]       cols_m1;
        logic [7:0]       rows_m1;
        cols_m1 = cols - 9'd1;
        rows_m1 = rows - 8'd1;
        if (cols == 9'd0) begin
            g.col_last = 8'd0;
        end else if (cols > 9'(tccle_pkg::COL_LIMIT)) begin
            g.col_last = 8'(tccle_pkg::COL_LIMIT - 1);
        end else begin
            g.col_last = cols_m1[7:0];
        end
        if (rows == 8'd0) begin
            g.row_last = 7'd0;
        end else if (rows > 8'(tccle_pkg::ROW_LIMIT)) begin
            g.row_last = 7'(tccle_pkg::ROW_LIMIT - 1);
        end else begin
            g.row_last = rows_m1[6:0];
        end
        return g;
    endfunction

    assign sel   = tccle_pkg::t_reg'(i_req.paddr[tccle_pkg::ADDR_W-1]);
    assign wr_en = i_req.psel && i_req.penable && i_req.pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= tccle_pkg::COLUMNS_RESET;
            r_rows    <= tccle_pkg::ROWS_RESET;
        end else if (wr_en) begin
            case (sel)
                tccle_pkg::REG_COLUMNS: r_columns <= i_req.pwdata[8:0];
                tccle_pkg::REG_ROWS:    r_rows    <= i_req.pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read data
    always_comb begin
        case (sel)
            tccle_pkg::REG_COLUMNS: o_prdata = {23'd0, r_columns};
            tccle_pkg::REG_ROWS:    o_prdata = {24'd0, r_rows};
            default:                o_prdata = '0;
        endcase
    end

    assign o_geom = clamp_geom(r_columns, r_rows);

endmodule

`default_nettype wire

// ===== hw/rtl/tccle_front.sv =====
// input side: accepts items and classifies them into commands
`default_nettype none

module tccle_front (
    tccle_in_if.sink             i_cmd,
    input  wire logic            i_full,
    output tccle_pkg::t_qword    o_push
);

    tccle_pkg::t_op op;
    logic           accept;

    assign i_cmd.ready = !i_full;
    assign accept      = i_cmd.valid && !i_full;

    // decode kind and character into a command
    always_comb begin
        op = tccle_pkg::OP_NONE;
        case (tccle_pkg::t_kind'(i_cmd.kind))
            tccle_pkg::KIND_DISPLAY: begin
                case (i_cmd.char_code)
                    tccle_pkg::CH_NL: op = tccle_pkg::OP_NEWLINE;
                    tccle_pkg::CH_CR: op = tccle_pkg::OP_RETURN;
                    tccle_pkg::CH_BS: op = tccle_pkg::OP_ERASE;
                    default:          op = tccle_pkg::OP_DRAW;
                endcase
            end
            tccle_pkg::KIND_KEY: begin
                case (i_cmd.char_code)
                    tccle_pkg::CH_NL: op = tccle_pkg::OP_KEY_ENTER;
                    tccle_pkg::CH_CR: op = tccle_pkg::OP_KEY_RETURN;
                    tccle_pkg::CH_BS: op = tccle_pkg::OP_KEY_BACK;
                    default:          op = tccle_pkg::OP_KEY_DRAW;
                endcase
            end
            tccle_pkg::KIND_CLEAR: op = tccle_pkg::OP_CLEAR;
            default:               op = tccle_pkg::OP_NONE;
        endcase
    end

    // unused kind is accepted and dropped here
    assign o_push.valid    = accept && (op != tccle_pkg::OP_NONE);
    assign o_push.cmd.op   = op;
    assign o_push.cmd.code = i_cmd.char_code;

endmodule

`default_nettype wire

// ===== hw/rtl/tccle_queue.sv =====
// short command fifo between front and back
`default_nettype none

module tccle_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tccle_pkg::t_qword  i_push,
    input  wire logic               i_pop,
    output logic                    o_full,
    output tccle_pkg::t_qword       o_head
);

    tccle_pkg::t_cmd                  r_mem [tccle_pkg::QUEUE_DEPTH];
    logic [tccle_pkg::PTR_W-1:0]      r_wr_ptr;
    logic [tccle_pkg::PTR_W-1:0]      r_rd_ptr;
    logic [tccle_pkg::CNT_W-1:0]      r_count;
    logic [tccle_pkg::CNT_W-1:0]      n_count;

    assign n_count = r_count + tccle_pkg::CNT_W'(i_push.valid)
                             - tccle_pkg::CNT_W'(i_pop);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    assign o_full       = (r_count == tccle_pkg::CNT_W'(tccle_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ===== hw/rtl/tccle_back.sv =====
// execution side: cursor state, line edit steps and the result register
`default_nettype none

module tccle_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tccle_pkg::t_qword  i_head,
    input  wire tccle_pkg::t_geom   i_geom,
    output logic                    o_pop,
    tccle_out_if.source             o_res
);

    // steps of a keyboard enter; other commands use only the first
    typedef enum logic [1:0] {
        STEP_NEWLINE = 2'd0,
        STEP_LINE    = 2'd1,
        STEP_ARROW   = 2'd2,
        STEP_SPACE   = 2'd3
    } t_step;

    typedef struct packed {
        tccle_pkg::t_action action;
        logic [7:0]         cell_column;
        logic [6:0]         cell_row;
        logic [7:0]         glyph;
        logic [7:0]         line_length;
        logic               last;
    } t_result;

    logic [7:0] r_col, n_col;
    logic [6:0] r_row, n_row;
    logic [7:0] r_prompt, n_prompt;
    logic [7:0] r_typed, n_typed;
    logic       r_clr_pend, n_pend;
    t_step      r_step, n_step;
    logic       r_out_valid;
    t_result    r_res, res;

    logic       step;
    logic       emit;
    logic       do_draw;
    logic       do_nl;
    logic [7:0] glyph;
    logic       step_done;
    logic       final_step;
    t_step      last_step;
    logic       col_over;
    logic       row_over;
    logic       room;
    logic [6:0] row_inc;

    assign step     = i_head.valid && (!r_out_valid || o_res.ready);
    assign col_over = (r_col >= i_geom.col_last);
    assign row_over = (r_row >= i_geom.row_last);
    assign room     = (r_typed < 8'(tccle_pkg::LINE_CAP));
    assign row_inc  = r_row + 7'd1;

    // one step of the current command, at most one result
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_prompt  = r_prompt;
        n_typed   = r_typed;
        n_pend    = r_clr_pend;
        n_step    = r_step;
        emit      = 1'b0;
        res       = '0;
        do_draw   = 1'b0;
        do_nl     = 1'b0;
        glyph     = tccle_pkg::CH_SP;
        step_done = 1'b0;

        if (r_clr_pend) begin
            // clear that follows a wrap past the last row
            emit       = 1'b1;
            res.action = tccle_pkg::ACT_CLEAR;
            n_pend     = 1'b0;
            step_done  = 1'b1;
        end else begin
            case (i_head.cmd.op)
                tccle_pkg::OP_CLEAR: begin
                    emit       = 1'b1;
                    res.action = tccle_pkg::ACT_CLEAR;
                    n_col      = 8'd0;
                    n_row      = 7'd0;
                    step_done  = 1'b1;
                end
                tccle_pkg::OP_NEWLINE: do_nl = 1'b1;
                tccle_pkg::OP_RETURN: begin
                    n_col     = 8'd0;
                    step_done = 1'b1;
                end
                tccle_pkg::OP_ERASE: begin
                    if (r_col != 8'd0) begin
                        n_col           = r_col - 8'd1;
                        emit            = 1'b1;
                        res.action      = tccle_pkg::ACT_DRAW;
                        res.cell_column = n_col;
                        res.cell_row    = r_row;
                        res.glyph       = tccle_pkg::CH_SP;
                    end
                    step_done = 1'b1;
                end
                tccle_pkg::OP_DRAW: begin
                    do_draw = 1'b1;
                    glyph   = i_head.cmd.code;
                end
                tccle_pkg::OP_KEY_DRAW: begin
                    if (room) begin
                        n_typed = r_typed + 8'd1;
                        do_draw = 1'b1;
                        glyph   = i_head.cmd.code;
                    end else begin
                        step_done = 1'b1;
                    end
                end
                tccle_pkg::OP_KEY_RETURN: begin
                    if (room) begin
                        n_typed = r_typed + 8'd1;
                        n_col   = 8'd0;
                    end
                    step_done = 1'b1;
                end
                tccle_pkg::OP_KEY_BACK: begin
                    // erase may step back across a row; on row 0 it stops at the prompt column
                    if (r_typed != 8'd0) begin
                        n_typed = r_typed - 8'd1;
                        if (r_col > r_prompt || r_row != 7'd0) begin
                            if (r_col == 8'd0 && r_row != 7'd0) begin
                                n_row = r_row - 7'd1;
                                n_col = i_geom.col_last;
                            end else if (r_col != 8'd0) begin
                                n_col = r_col - 8'd1;
                            end
                            emit            = 1'b1;
                            res.action      = tccle_pkg::ACT_DRAW;
                            res.cell_column = n_col;
                            res.cell_row    = n_row;
                            res.glyph       = tccle_pkg::CH_SP;
                        end
                    end
                    step_done = 1'b1;
                end
                tccle_pkg::OP_KEY_ENTER: begin
                    case (r_step)
                        STEP_NEWLINE: do_nl = 1'b1;
                        STEP_LINE: begin
                            emit            = 1'b1;
                            res.action      = tccle_pkg::ACT_LINE;
                            res.line_length = r_typed;
                            n_typed         = 8'd0;
                            step_done       = 1'b1;
                        end
                        STEP_ARROW: begin
                            do_draw = 1'b1;
                            glyph   = tccle_pkg::CH_GT;
                        end
                        STEP_SPACE: begin
                            do_draw = 1'b1;
                            glyph   = tccle_pkg::CH_SP;
                        end
                        default: step_done = 1'b1;
                    endcase
                end
                default: step_done = 1'b1;
            endcase
        end

        // glyph at the cursor
        if (do_draw) begin
            emit            = 1'b1;
            res.action      = tccle_pkg::ACT_DRAW;
            res.cell_column = r_col;
            res.cell_row    = r_row;
            res.glyph       = glyph;
        end

        // advance, wrap and clear past the last row
        if (do_draw || do_nl) begin
            if (do_nl || col_over) begin
                n_col = 8'd0;
                if (row_over) begin
                    n_row  = 7'd0;
                    n_pend = 1'b1;
                end else begin
                    n_row = row_inc;
                end
            end else begin
                n_col = r_col + 8'd1;
            end
            step_done = !n_pend;
        end

        // step sequencing and end of command
        last_step  = (i_head.cmd.op == tccle_pkg::OP_KEY_ENTER) ? STEP_SPACE : STEP_NEWLINE;
        final_step = step_done && (r_step == last_step);
        if (step_done) begin
            n_step = final_step ? STEP_NEWLINE : t_step'(r_step + 2'd1);
        end
        if (final_step && i_head.cmd.op == tccle_pkg::OP_KEY_ENTER) begin
            n_prompt = n_col;
        end
        res.last = final_step;
    end

    assign o_pop = step && final_step;

    // cursor and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= 8'd0;
            r_row      <= 7'd0;
            r_prompt   <= 8'd0;
            r_typed    <= 8'd0;
            r_clr_pend <= 1'b0;
            r_step     <= STEP_NEWLINE;
        end else if (step) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_prompt   <= n_prompt;
            r_typed    <= n_typed;
            r_clr_pend <= n_pend;
            r_step     <= n_step;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_res <= res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.action      = r_res.action;
    assign o_res.cell_column = r_res.cell_column;
    assign o_res.cell_row    = r_res.cell_row;
    assign o_res.glyph       = r_res.glyph;
    assign o_res.line_length = r_res.line_length;
    assign o_res.last        = r_res.last;

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_cursor_line_editor.sv =====
// Cursor and line-edit engine of a character-cell console. Items (display character,
// keyboard character, clear) enter on i_cmd; draw, clear and line-complete results leave
// on o_res, one per cycle while o_res.ready is high, with last set on the final result of
// an item. The front classifies an item in the cycle it is accepted and writes it to a
// 4-entry command queue; i_cmd.ready is low only while that queue is full. The back
// executes one step per cycle while the output is not stalled, into a single output
// register. Most items take one back step, so one item per cycle is sustained without
// stalls; a character or newline that wraps past the last row takes two steps (the
// extra one for the clear), and a keyboard enter takes four to seven steps, one per result
// plus the newline. Geometry registers sit on the APB port: columns at 0x0, rows at 0x4,
// clamped to 1..256 and 1..128; write them only while no item is in flight.
`default_nettype none

module text_console_cursor_line_editor (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    tccle_in_if.sink                           i_cmd,
    tccle_out_if.source                        o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tccle_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [tccle_pkg::DATA_W-1:0]  pwdata,
    output logic      [tccle_pkg::DATA_W-1:0]  prdata,
    output logic                               pready
);

    tccle_pkg::t_apb_req apb_req;
    tccle_pkg::t_geom    geom;
    tccle_pkg::t_qword   push;
    tccle_pkg::t_qword   head;
    logic                full;
    logic                pop;

    assign pready          = 1'b1;
    assign apb_req.psel    = psel;
    assign apb_req.penable = penable;
    assign apb_req.pwrite  = pwrite;
    assign apb_req.paddr   = paddr;
    assign apb_req.pwdata  = pwdata;

    // geometry registers
    tccle_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (apb_req),
        .o_prdata (prdata),
        .o_geom   (geom)
    );

    // accept and classify
    tccle_front u_front (
        .i_cmd  (i_cmd),
        .i_full (full),
        .o_push (push)
    );

    // command queue
    tccle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // execute and emit results
    tccle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_geom  (geom),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tccle_checker.sv =====
// port-level checks of the console engine, bound to the top level
`default_nettype none

module tccle_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_cmd_ready,
    input wire logic       i_res_valid,
    input wire logic       i_res_ready,
    input wire logic [1:0] i_res_action,
    input wire logic [7:0] i_res_cell_column,
    input wire logic [6:0] i_res_cell_row,
    input wire logic [7:0] i_res_glyph,
    input wire logic [7:0] i_res_line_length,
    input wire logic       i_res_last
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable(i_res_action) && $stable(i_res_cell_column) && $stable(i_res_cell_row)
            && $stable(i_res_glyph) && $stable(i_res_line_length) && $stable(i_res_last))
        else $error("result payload changed while stalled");

    // line complete is never the final result of an item; the prompt echo follows it
    a_line_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_action == tccle_pkg::ACT_LINE) |-> !i_res_last)
        else $error("line complete marked as final result");

    // reset empties the queue and the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid && i_cmd_ready)
        else $error("engine not empty after reset");

endmodule

bind text_console_cursor_line_editor tccle_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_ready       (i_cmd.ready),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_action      (o_res.action),
    .i_res_cell_column (o_res.cell_column),
    .i_res_cell_row    (o_res.cell_row),
    .i_res_glyph       (o_res.glyph),
    .i_res_line_length (o_res.line_length),
    .i_res_last        (o_res.last)
);

`default_nettype wire

// ===== verif/text_console_cursor_line_editor_test.sv =====
// self-checking testbench for the text console cursor and line editor
`timescale 1ns / 1ps

module text_console_cursor_line_editor_test;
    import tccle_pkg::*;

    // kind code that the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // one draw, clear or line-complete transaction
    typedef struct packed {
        t_action    action;
        logic [7:0] col;
        logic [6:0] row;
        logic [7:0] glyph;
        logic [7:0] len;
        logic       last;
    } t_event;

    // row of the directed stimulus table; typed_n < 0 means use the predictor
    typedef struct {
        logic [1:0] kind;
        logic [7:0] code;
        int         typed_n;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    tccle_in_if  cmd_if ();
    tccle_out_if res_if ();

    text_console_cursor_line_editor u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted console state and geometry
    logic [8:0]  cfg_cols = COLUMNS_RESET;
    logic [7:0]  cfg_rows = ROWS_RESET;
    int unsigned cur_col    = 0;
    int unsigned cur_row    = 0;
    int unsigned prompt_col = 0;
    int unsigned typed_len  = 0;

    t_event   step_events[$];
    t_event   due_events[$];
    t_event   dir_events[$];
    t_dir_row dir_rows[$];

    int snd_idle    = 0;
    int rcv_idle    = 0;
    int hold_cycles = 0;
    int errors      = 0;
    int items_sent  = 0;
    int results_seen = 0;
    int clears_seen = 0;
    int lines_seen  = 0;
    int reg_writes  = 0;

    // clamped geometry
    function automatic int unsigned eff_cols();
        int unsigned c;
        c = cfg_cols;
        if (c < 1) c = 1;
        if (c > COL_LIMIT) c = COL_LIMIT;
        return c;
    endfunction

    function automatic int unsigned eff_rows();
        int unsigned r;
        r = cfg_rows;
        if (r < 1) r = 1;
        if (r > ROW_LIMIT) r = ROW_LIMIT;
        return r;
    endfunction

    function automatic void note_event(t_action a, int unsigned col, int unsigned row,
                                       int unsigned glyph, int unsigned len);
        t_event e;
        e.action = a;
        e.col    = 8'(col);
        e.row    = 7'(row);
        e.glyph  = 8'(glyph);
        e.len    = 8'(len);
        e.last   = 1'b0;
        step_events.push_back(e);
    endfunction

    function automatic void screen_clear();
        cur_col = 0;
        cur_row = 0;
        note_event(ACT_CLEAR, 0, 0, 0, 0);
    endfunction

    // newline, clearing the screen when it runs past the last row
    function automatic void line_feed();
        cur_col = 0;
        cur_row = cur_row + 1;
        if (cur_row >= eff_rows()) screen_clear();
        cur_row = cur_row & 'h7F;
    endfunction

    // display character: control codes or a glyph followed by advance and wrap
    function automatic void show_char(logic [7:0] c);
        if (c == CH_NL) begin
            line_feed();
        end else if (c == CH_CR) begin
            cur_col = 0;
        end else if (c == CH_BS) begin
            if (cur_col > 0) begin
                cur_col = cur_col - 1;
                note_event(ACT_DRAW, cur_col, cur_row, CH_SP, 0);
            end
        end else begin
            note_event(ACT_DRAW, cur_col, cur_row, c, 0);
            cur_col = cur_col + 1;
            if (cur_col >= eff_cols()) line_feed();
            cur_col = cur_col & 'hFF;
        end
    endfunction

    // expected transactions of one accepted item, left in step_events
    function automatic void console_step(logic [1:0] k, logic [7:0] c);
        int unsigned len;
        step_events.delete();
        case (k)
            KIND_DISPLAY: begin
                show_char(c);
            end
            KIND_KEY: begin
                if (c == CH_NL) begin
                    len = typed_len;
                    show_char(CH_NL);
                    note_event(ACT_LINE, 0, 0, 0, len);
                    typed_len = 0;
                    show_char(CH_GT);
                    show_char(CH_SP);
                    prompt_col = cur_col;
                end else if (c == CH_BS) begin
                    if (typed_len > 0) begin
                        typed_len = typed_len - 1;
                        // erase only past the prompt or on a lower row
                        if (cur_col > prompt_col || cur_row > 0) begin
                            if (cur_col == 0 && cur_row > 0) begin
                                cur_row = cur_row - 1;
                                cur_col = (eff_cols() - 1) & 'hFF;
                            end else if (cur_col > 0) begin
                                cur_col = cur_col - 1;
                            end
                            note_event(ACT_DRAW, cur_col, cur_row, CH_SP, 0);
                        end
                    end
                end else if (typed_len < LINE_CAP) begin
                    typed_len = typed_len + 1;
                    show_char(c);
                end
            end
            KIND_CLEAR: begin
                screen_clear();
            end
            default: ;
        endcase
        if (step_events.size() > 0) step_events[$].last = 1'b1;
    endfunction

    // directed table builders
    function automatic void dir_add(logic [1:0] k, logic [7:0] c, int n);
        t_dir_row r;
        r.kind    = k;
        r.code    = c;
        r.typed_n = n;
        dir_rows.push_back(r);
    endfunction

    function automatic void dir_ev(t_action a, int unsigned col, int unsigned row,
                                   int unsigned glyph, int unsigned len, logic last);
        note_event(a, col, row, glyph, len);
        dir_events.push_back(step_events.pop_back());
        dir_events[$].last = last;
    endfunction

    // offer one item, wait for acceptance, then queue its expectations
    task automatic push_cmd(input logic [1:0] k, input logic [7:0] c, input int typed_n);
        while ($urandom_range(0, 99) < snd_idle) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.kind      <= k;
        cmd_if.char_code <= c;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        items_sent++;
        console_step(k, c);
        if (typed_n < 0) begin
            foreach (step_events[i]) due_events.push_back(step_events[i]);
        end else begin
            repeat (typed_n) due_events.push_back(dir_events.pop_front());
        end
        @(negedge i_clk);
    endtask

    // stop offering and wait for all expected transactions plus the pipeline tail
    task automatic settle();
        int waited;
        waited = 0;
        cmd_if.valid <= 1'b0;
        while (due_events.size() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (20) @(negedge i_clk);
    endtask

    // apb write: setup then access phase
    task automatic write_reg(input t_reg idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_COLUMNS) cfg_cols = 9'(value);
        else cfg_rows = 8'(value);
        reg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mixed traffic, mostly line editing and display text
    task automatic random_traffic(input int n, input int key_pct);
        int         r;
        logic [1:0] k;
        logic [7:0] c;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < key_pct) begin
                k = KIND_KEY;
                r = $urandom_range(0, 99);
                if (r < 12) c = CH_NL;
                else if (r < 30) c = CH_BS;
                else if (r < 34) c = CH_CR;
                else if (r < 44) c = 8'($urandom_range(0, 255));
                else c = 8'($urandom_range(32, 126));
            end else if (r < key_pct + 5) begin
                k = KIND_CLEAR;
                c = 8'($urandom);
            end else if (r < key_pct + 8) begin
                k = KIND_UNUSED;
                c = 8'($urandom);
            end else begin
                k = KIND_DISPLAY;
                r = $urandom_range(0, 99);
                if (r < 10) c = CH_NL;
                else if (r < 18) c = CH_BS;
                else if (r < 22) c = CH_CR;
                else c = 8'($urandom_range(0, 255));
            end
            push_cmd(k, c, -1);
        end
    endtask

    // result side ready, with random stalls and requested long hold-offs
    initial begin : result_sink
        res_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // compare each accepted transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_event want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (due_events.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction: expected none, got action %0d col %0d row %0d glyph %0d",
                         $time, res_if.action, res_if.cell_column, res_if.cell_row,
                         res_if.glyph);
            end else begin
                want = due_events.pop_front();
                if (want.action == ACT_CLEAR) clears_seen++;
                if (want.action == ACT_LINE) lines_seen++;
                check_field("action", 8'(want.action), 8'(res_if.action));
                check_field("cell_column", want.col, res_if.cell_column);
                check_field("cell_row", 8'(want.row), 8'(res_if.cell_row));
                check_field("glyph", want.glyph, res_if.glyph);
                check_field("line_length", want.len, res_if.line_length);
                check_field("last", 8'(want.last), 8'(res_if.last));
            end
        end
    end

    // run limit
    initial begin : watchdog
        #5_000_000;
        $display("text_console_cursor_line_editor_test: FAIL");
        $finish;
    end

    // stimulus sequence
    initial begin : stimulus
        i_rst_n          <= 1'b0;
        cmd_if.valid     <= 1'b0;
        cmd_if.kind      <= KIND_DISPLAY;
        cmd_if.char_code <= 8'd0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;

        // directed table at the reset geometry of 80 x 25
        dir_add(KIND_DISPLAY, 8'h41, 1);  dir_ev(ACT_DRAW, 0, 0, 8'h41, 0, 1'b1);
        dir_add(KIND_DISPLAY, CH_BS, 1);  dir_ev(ACT_DRAW, 0, 0, CH_SP, 0, 1'b1);
        dir_add(KIND_DISPLAY, CH_BS, 0);  // backspace at column zero
        dir_add(KIND_DISPLAY, CH_CR, 0);
        dir_add(KIND_DISPLAY, CH_NL, 0);
        dir_add(KIND_DISPLAY, 8'h00, 1);  dir_ev(ACT_DRAW, 0, 1, 8'h00, 0, 1'b1);
        dir_add(KIND_DISPLAY, 8'hFF, 1);  dir_ev(ACT_DRAW, 1, 1, 8'hFF, 0, 1'b1);
        dir_add(KIND_UNUSED, 8'hFF, 0);
        dir_add(KIND_CLEAR, 8'h00, 1);    dir_ev(ACT_CLEAR, 0, 0, 0, 0, 1'b1);
        dir_add(KIND_KEY, 8'h78, 1);      dir_ev(ACT_DRAW, 0, 0, 8'h78, 0, 1'b1);
        dir_add(KIND_KEY, CH_CR, 0);      // counted, cursor back to column zero
        dir_add(KIND_KEY, CH_BS, 0);      // at the prompt: count drops, no erase
        dir_add(KIND_KEY, CH_BS, 0);
        dir_add(KIND_KEY, CH_BS, 0);      // empty line
        dir_add(KIND_KEY, CH_NL, 3);      // enter with nothing typed
        dir_ev(ACT_LINE, 0, 0, 0, 0, 1'b0);
        dir_ev(ACT_DRAW, 0, 1, CH_GT, 0, 1'b0);
        dir_ev(ACT_DRAW, 1, 1, CH_SP, 0, 1'b1);
        dir_add(KIND_KEY, 8'h61, -1);
        dir_add(KIND_KEY, CH_BS, -1);
        dir_add(KIND_KEY, CH_BS, -1);
        dir_add(KIND_KEY, 8'hAA, -1);
        dir_add(KIND_KEY, 8'h55, -1);
        dir_add(KIND_KEY, CH_NL, -1);
        dir_add(KIND_UNUSED, 8'h00, 0);

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sender idles rarely, receiver often
        snd_idle = 13;
        rcv_idle = 58;
        foreach (dir_rows[i]) push_cmd(dir_rows[i].kind, dir_rows[i].code, dir_rows[i].typed_n);
        settle();

        // largest screen, with a long receiver hold-off to back up the input
        write_reg(REG_COLUMNS, 256);
        write_reg(REG_ROWS, 128);
        hold_cycles = 60;
        random_traffic(10, 30);
        settle();
        random_traffic(8, 30);
        repeat (6) push_cmd(KIND_DISPLAY, 8'($urandom_range(33, 126)), -1);
        settle();

        // shrink below the cursor position
        write_reg(REG_COLUMNS, 5);
        write_reg(REG_ROWS, 3);
        random_traffic(12, 60);
        settle();

        // receiver idles rarely, sender often; zero registers clamp to 1 x 1
        snd_idle = 58;
        rcv_idle = 13;
        write_reg(REG_COLUMNS, 0);
        write_reg(REG_ROWS, 0);
        random_traffic(10, 60);
        settle();

        // type across several rows, erase back across rows, then enter
        write_reg(REG_COLUMNS, 7);
        write_reg(REG_ROWS, 128);
        repeat (14) push_cmd(KIND_KEY, 8'($urandom_range(32, 126)), -1);
        repeat (10) push_cmd(KIND_KEY, CH_BS, -1);
        push_cmd(KIND_KEY, CH_NL, -1);
        settle();

        // no idling; out-of-range values clamp to the maximum
        snd_idle = 0;
        rcv_idle = 0;
        write_reg(REG_COLUMNS, 511);
        write_reg(REG_ROWS, 255);
        random_traffic(5, 50);
        settle();
        write_reg(REG_COLUMNS, 2);
        write_reg(REG_ROWS, 2);
        random_traffic(5, 50);
        settle();

        if (due_events.size() != 0) begin
            errors++;
            $display("%0t: %0d expected transactions never arrived", $time, due_events.size());
        end

        $display("covered %0d items and %0d transactions (%0d clears, %0d line completions)",
                 items_sent, results_seen, clears_seen, lines_seen);
        $display("over %0d register writes, with stalls on both sides and a full input queue",
                 reg_writes);
        if (errors == 0) begin
            $display("text_console_cursor_line_editor_test: PASS");
        end else begin
            $display("text_console_cursor_line_editor_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tccle_pkg.sv
hw/rtl/tccle_if.sv
hw/rtl/tccle_cfg.sv
hw/rtl/tccle_front.sv
hw/rtl/tccle_queue.sv
hw/rtl/tccle_back.sv
hw/rtl/text_console_cursor_line_editor.sv
hw/rtl/tccle_checker.sv
verif/text_console_cursor_line_editor_test.sv
